// ----- hdl/lurw_pkg.sv -----
// Shared types, constants and fixed-point helpers for the lens warp pipeline.
package lurw_pkg;

  localparam int MAX_ROWS_DEF   = 4096;
  localparam int COORD_FRAC_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int ELEMS     = 9;
  localparam int ROW_IDX_W = 14;
  localparam int Q28_BITS  = 28;
  localparam int QUOT_W    = 33;
  localparam int DU_W      = 40;

  localparam logic MODE_LOAD = 1'b0;

  localparam logic [31:0] FOCAL_RESET = 32'd65536000;
  localparam logic [23:0] ZOOM_RESET  = 24'd65536;

  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_TANGENTIAL = 3'd6,
    REG_ZOOM       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ROW = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  // Control that travels with every request down the pipe.
  typedef struct packed {
    logic                 load;
    logic                 row_bad;
    logic                 focal_bad;
    logic                 zbad;
    logic                 sat;
    logic [ROW_IDX_W-1:0] row;
    logic [3:0]           elem;
    logic [31:0]          value;
  } item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] v;
  } sat_t;

  // Clamp to the signed 32-bit range and flag any clamping.
  function automatic sat_t sat32(input logic signed [63:0] a);
    sat_t r;
    r.ovf = 1'b0;
    r.v   = a[31:0];
    if (a > 64'sd2147483647) begin
      r.ovf = 1'b1;
      r.v   = 32'sh7FFFFFFF;
    end else if (a < -64'sd2147483648) begin
      r.ovf = 1'b1;
      r.v   = 32'sh80000000;
    end
    return r;
  endfunction

  // Q4.28 product, floor rounded.
  function automatic logic signed [35:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 36'(p >>> Q28_BITS);
  endfunction

endpackage

// ----- hdl/lurw_if.sv -----
// Request and result channel interfaces of the lens warp block.
interface lurw_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [20:0]        in_u;
  logic [20:0]        in_v;
  logic [11:0]        table_row;
  logic [3:0]         table_element;
  logic signed [31:0] element_value;

  modport source (output valid, mode, in_u, in_v, table_row, table_element, element_value,
                  input ready);
  modport sink (input valid, mode, in_u, in_v, table_row, table_element, element_value,
                output ready);
endinterface

interface lurw_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_u;
  logic signed [23:0] out_v;
  logic [1:0]         status;

  modport source (output valid, out_u, out_v, status, input ready);
  modport sink (input valid, out_u, out_v, status, output ready);
endinterface

// ----- hdl/lurw_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage, 32-bit saturated result.
module lurw_div #(
  parameter int N_W    = 68,
  parameter int D_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [1:0][N_W-1:0]    num_mag,
  input  logic [1:0]             num_neg,
  input  logic [1:0][D_W-1:0]    den,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_vld,
  output logic [1:0][31:0]       quot,
  output logic [1:0]             quot_sat,
  output logic [SIDE_W-1:0]      side_out
);
  import lurw_pkg::*;

  localparam int Q_W = QUOT_W;
  localparam logic [Q_W-1:0] POS_LIM = Q_W'(32'h7FFFFFFF);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(32'h80000000);

  logic                 vld  [Q_W+1];
  logic [1:0][D_W-1:0]  rem  [Q_W+1];
  logic [1:0][Q_W-1:0]  low  [Q_W+1];
  logic [1:0][D_W-1:0]  dv   [Q_W+1];
  logic [1:0]           neg  [Q_W+1];
  logic [1:0]           ovf  [Q_W+1];
  logic [SIDE_W-1:0]    side [Q_W+1];

  logic [1:0]           hi_ovf;
  logic [1:0][31:0]     q_val;
  logic [1:0]           q_sat;

  // quotient of 2^33 or more: saturate whatever the remaining bits say
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi_ovf[l] = num_mag[l][N_W-1:Q_W] >= den[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= hi_ovf[l] ? '0 : D_W'(num_mag[l][N_W-1:Q_W]);
        low[0][l] <= num_mag[l][Q_W-1:0];
      end
      dv[0]   <= den;
      neg[0]  <= num_neg;
      ovf[0]  <= hi_ovf;
      side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [1:0][D_W:0] t;
    logic [1:0]        take;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]    = {rem[k][l], low[k][l][Q_W-1]};
        take[l] = t[l] >= {1'b0, dv[k][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rem[k+1][l] <= take[l] ? D_W'(t[l] - {1'b0, dv[k][l]}) : t[l][D_W-1:0];
          low[k+1][l] <= {low[k][l][Q_W-2:0], take[l]};
        end
        dv[k+1]   <= dv[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
        side[k+1] <= side[k];
      end
    end
  end

  // truncate toward zero: negate the magnitude quotient
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_sat[l] = ovf[Q_W][l] || (!neg[Q_W][l] && low[Q_W][l] > POS_LIM) ||
                 (neg[Q_W][l] && low[Q_W][l] > NEG_LIM);
      if (q_sat[l]) begin
        q_val[l] = neg[Q_W][l] ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (neg[Q_W][l]) begin
        q_val[l] = ~low[Q_W][l][31:0] + 32'd1;
      end else begin
        q_val[l] = low[Q_W][l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= q_val;
      quot_sat <= q_sat;
      side_out <= side[Q_W];
    end
  end

endmodule

// ----- hdl/lurw_dist.sv -----
// Brown-Conrady radial and tangential distortion, six register stages.
module lurw_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  lurw_pkg::item_t     item_in,
  input  logic signed [31:0]  k1,
  input  logic signed [31:0]  k2,
  input  logic signed [31:0]  p1,
  input  logic signed [31:0]  p2,
  output logic                out_vld,
  output logic signed [31:0]  x2,
  output logic signed [31:0]  y2,
  output lurw_pkg::item_t     item_out
);
  import lurw_pkg::*;

  logic [4:0] vld;
  item_t      itm [5];

  logic signed [31:0] a_x, a_y, a_xx, a_yy, a_xy;
  logic signed [31:0] b_x, b_y, b_xx, b_yy, b_xy, b_r2;
  logic signed [31:0] c_x, c_y, c_xy, c_r4, c_ta, c_tb;
  logic signed [35:0] c_k1r2;
  logic signed [31:0] d_x, d_y;
  logic signed [35:0] d_k1r2, d_k2r4, d_t1, d_t2, d_t3, d_t4;
  logic signed [31:0] e_x, e_y, e_rad;
  logic signed [37:0] e_tx, e_ty;

  sat_t  xx_c, yy_c, xy_c, r2_c, r4_c, ta_c, tb_c, rad_c, x2_c, y2_c;
  item_t a_it, b_it, c_it, e_it, f_it;

  always_comb begin
    xx_c = sat32(qmul(x_in, x_in));
    yy_c = sat32(qmul(y_in, y_in));
    xy_c = sat32(qmul(x_in, y_in));
    a_it = item_in;
    a_it.sat = item_in.sat | xx_c.ovf | yy_c.ovf | xy_c.ovf;

    r2_c = sat32(64'(a_xx) + 64'(a_yy));
    b_it = itm[0];
    b_it.sat = itm[0].sat | r2_c.ovf;

    r4_c = sat32(qmul(b_r2, b_r2));
    ta_c = sat32(64'(b_r2) + 2 * 64'(b_xx));
    tb_c = sat32(64'(b_r2) + 2 * 64'(b_yy));
    c_it = itm[1];
    c_it.sat = itm[1].sat | r4_c.ovf | ta_c.ovf | tb_c.ovf;

    rad_c = sat32(ONE_Q28 + 64'(d_k1r2) + 64'(d_k2r4));
    e_it = itm[3];
    e_it.sat = itm[3].sat | rad_c.ovf;

    x2_c = sat32(64'(qmul(e_x, e_rad)) + 64'(e_tx));
    y2_c = sat32(64'(qmul(e_y, e_rad)) + 64'(e_ty));
    f_it = itm[4];
    f_it.sat = itm[4].sat | x2_c.ovf | y2_c.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // squares and cross term
      a_x  <= x_in;
      a_y  <= y_in;
      a_xx <= xx_c.v;
      a_yy <= yy_c.v;
      a_xy <= xy_c.v;
      itm[0] <= a_it;
      // r squared
      b_x  <= a_x;
      b_y  <= a_y;
      b_xx <= a_xx;
      b_yy <= a_yy;
      b_xy <= a_xy;
      b_r2 <= r2_c.v;
      itm[1] <= b_it;
      // r^4, k1 term, tangential sums
      c_x    <= b_x;
      c_y    <= b_y;
      c_xy   <= b_xy;
      c_r4   <= r4_c.v;
      c_k1r2 <= qmul(k1, b_r2);
      c_ta   <= ta_c.v;
      c_tb   <= tb_c.v;
      itm[2] <= c_it;
      // remaining coefficient products
      d_x    <= c_x;
      d_y    <= c_y;
      d_k1r2 <= c_k1r2;
      d_k2r4 <= qmul(k2, c_r4);
      d_t1   <= qmul(p1, c_xy);
      d_t2   <= qmul(p2, c_ta);
      d_t3   <= qmul(p1, c_tb);
      d_t4   <= qmul(p2, c_xy);
      itm[3] <= itm[2];
      // radial factor and tangential offsets
      e_x   <= d_x;
      e_y   <= d_y;
      e_rad <= rad_c.v;
      e_tx  <= 38'(2 * 64'(d_t1) + 64'(d_t2));
      e_ty  <= 38'(64'(d_t3) + 2 * 64'(d_t4));
      itm[4] <= e_it;
      // distorted point
      x2       <= x2_c.v;
      y2       <= y2_c.v;
      item_out <= f_it;
    end
  end

endmodule

// ----- hdl/lurw_rot.sv -----
// Per-row rotation table and 3x3 matrix product, three register stages.
module lurw_rot #(
  parameter int MAX_ROWS = lurw_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [31:0]  x2,
  input  logic signed [31:0]  y2,
  input  lurw_pkg::item_t     item_in,
  output logic                out_vld,
  output logic signed [35:0]  rx,
  output logic signed [35:0]  ry,
  output logic signed [35:0]  rz,
  output lurw_pkg::item_t     item_out
);
  import lurw_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROW_W-1:0]   addr;
  logic               we;
  logic signed [31:0] m_rd [ELEMS];

  logic               m_vld, p_vld;
  logic signed [31:0] m_x, m_y;
  item_t              m_item, p_item, z_item;
  logic signed [33:0] pr   [ELEMS];
  logic signed [33:0] pr_c [ELEMS];
  logic signed [35:0] rz_c;

  assign addr = item_in.row[ROW_W-1:0];
  assign we   = en && in_vld && item_in.load && !item_in.row_bad;

  // one bank per matrix element, so all nine elements of a matrix are read together
  for (genvar e = 0; e < ELEMS; e++) begin : g_bank
    logic signed [31:0] mem [MAX_ROWS];

    always_ff @(posedge clk) begin
      if (we && item_in.elem == 4'(e)) begin
        mem[addr] <= item_in.value;
      end
      if (en) begin
        m_rd[e] <= mem[addr];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_c[3*i]   = 34'((64'(m_rd[3*i])   * 64'(m_x)) >>> 30);
      pr_c[3*i+1] = 34'((64'(m_rd[3*i+1]) * 64'(m_y)) >>> 30);
      pr_c[3*i+2] = 34'(m_rd[3*i+2] >>> 2);
    end
    rz_c = 36'(pr[6]) + 36'(pr[7]) + 36'(pr[8]);
    // flag a depth of zero or below alongside the item
    z_item      = p_item;
    z_item.zbad = rz_c <= 36'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld   <= 1'b0;
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      m_vld   <= in_vld;
      p_vld   <= m_vld;
      out_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x      <= x2;
      m_y      <= y2;
      m_item   <= item_in;
      pr       <= pr_c;
      p_item   <= m_item;
      rx       <= 36'(pr[0]) + 36'(pr[1]) + 36'(pr[2]);
      ry       <= 36'(pr[3]) + 36'(pr[4]) + 36'(pr[5]);
      rz       <= rz_c;
      item_out <= z_item;
    end
  end

endmodule

// ----- hdl/lurw_proj.sv -----
// Reprojection to pixels, status selection and the output register.
module lurw_proj #(
  parameter int COORD_FRAC_BITS = lurw_pkg::COORD_FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [31:0]  n_x,
  input  logic signed [31:0]  n_y,
  input  lurw_pkg::item_t     item_in,
  input  logic [31:0]         focal_x,
  input  logic [31:0]         focal_y,
  input  logic [31:0]         center_x,
  input  logic [31:0]         center_y,
  input  logic [23:0]         zoom,
  input  logic                out_ready,
  output logic                adv,
  output logic                out_vld,
  output logic signed [23:0]  out_u,
  output logic signed [23:0]  out_v,
  output logic [1:0]          status
);
  import lurw_pkg::*;

  localparam int PIX_SHIFT = 16 - COORD_FRAC_BITS;
  localparam logic signed [45:0] OUT_MAX = 46'sd8388607;
  localparam logic signed [45:0] OUT_MIN = -46'sd8388608;

  logic               out_en;
  logic               a_vld, b_vld;
  item_t              a_item, b_item;
  logic signed [35:0] a_tx, a_ty;
  logic signed [45:0] b_tx, b_ty;

  logic signed [45:0] o_x, o_y;
  logic               sx, sy;
  logic signed [23:0] u_c, v_c;
  status_t            st_c;

  assign out_en = !out_vld || out_ready;
  assign adv    = out_en || !b_vld;

  always_comb begin
    o_x = b_tx >>> PIX_SHIFT;
    o_y = b_ty >>> PIX_SHIFT;
    sx  = (o_x > OUT_MAX) || (o_x < OUT_MIN);
    sy  = (o_y > OUT_MAX) || (o_y < OUT_MIN);
    u_c = sx ? ((o_x > OUT_MAX) ? OUT_MAX[23:0] : OUT_MIN[23:0]) : o_x[23:0];
    v_c = sy ? ((o_y > OUT_MAX) ? OUT_MAX[23:0] : OUT_MIN[23:0]) : o_y[23:0];
    st_c = (b_item.sat || sx || sy) ? ST_BAD : ST_OK;
    if (b_item.load) begin
      u_c  = '0;
      v_c  = '0;
      st_c = b_item.row_bad ? ST_ROW : ST_OK;
    end else if (b_item.row_bad) begin
      u_c  = OUT_MAX[23:0];
      v_c  = OUT_MAX[23:0];
      st_c = ST_ROW;
    end else if (b_item.focal_bad || b_item.zbad) begin
      u_c  = OUT_MAX[23:0];
      v_c  = OUT_MAX[23:0];
      st_c = ST_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (adv) begin
        a_vld <= in_vld;
        b_vld <= a_vld;
      end
      if (out_en) begin
        out_vld <= b_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tx   <= 36'((64'(n_x) * $signed({32'd0, focal_x})) >>> Q28_BITS);
      a_ty   <= 36'((64'(n_y) * $signed({32'd0, focal_y})) >>> Q28_BITS);
      a_item <= item_in;
      b_tx   <= 46'(((64'(a_tx) * $signed({40'd0, zoom})) >>> 16) + $signed({32'd0, center_x}));
      b_ty   <= 46'(((64'(a_ty) * $signed({40'd0, zoom})) >>> 16) + $signed({32'd0, center_y}));
      b_item <= a_item;
    end
    if (out_en) begin
      out_u  <= u_c;
      out_v  <= v_c;
      status <= st_c;
    end
  end

endmodule

// ----- hdl/lens_undistort_rotate_warp.sv -----
// Top level of the lens undistortion, rolling-shutter rotation and reprojection warp.
//
// One request enters per clock and one result leaves per clock while the
// result channel does not stall; most of the pipe is the two 35-stage
// dividers (normalisation by focal length and the perspective divide),
// which retire one quotient bit per stage. A map request (mode 1)
// centres the pixel, normalises it, applies radial and tangential distortion,
// rotates it by the matrix of its rounded row, divides by depth and scales
// back to pixels. A load request (mode 0) writes one matrix element; the
// write lands in the table at the same pipe stage as map reads, so every map
// request sees exactly the loads taken before it. The table has no reset and
// needs no clearing: a row must be loaded before it is mapped. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no request is in flight. A stalled result register holds
// while earlier empty stages keep advancing, so a waiting result does not
// block intake until the stage behind it is occupied.
module lens_undistort_rotate_warp #(
  parameter int MAX_ROWS        = lurw_pkg::MAX_ROWS_DEF,
  parameter int COORD_FRAC_BITS = lurw_pkg::COORD_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  lurw_in_if.sink                             items,
  lurw_out_if.source                          results,
  input  logic                                cfg_we,
  input  logic [lurw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lurw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lurw_pkg::*;

  localparam int HALF      = (1 << COORD_FRAC_BITS) >> 1;
  localparam int PIX_SHIFT = 16 - COORD_FRAC_BITS;
  localparam int NORM_N_W  = DU_W + Q28_BITS;
  localparam int PROJ_N_W  = 36 + Q28_BITS;

  // configuration registers
  logic [31:0] focal_x, focal_y, center_x, center_y, radial_k1, radial_k2;
  logic [63:0] tan_pair;
  logic [23:0] zoom;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x   <= FOCAL_RESET;
      focal_y   <= FOCAL_RESET;
      center_x  <= '0;
      center_y  <= '0;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tan_pair  <= '0;
      zoom      <= ZOOM_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:    focal_x   <= cfg_data[31:0];
        REG_FOCAL_Y:    focal_y   <= cfg_data[31:0];
        REG_CENTER_X:   center_x  <= cfg_data[31:0];
        REG_CENTER_Y:   center_y  <= cfg_data[31:0];
        REG_RADIAL_K1:  radial_k1 <= cfg_data[31:0];
        REG_RADIAL_K2:  radial_k2 <= cfg_data[31:0];
        REG_TANGENTIAL: tan_pair  <= cfg_data;
        REG_ZOOM:       zoom      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // pipe advance comes from the output end; every stage moves together
  logic adv;
  assign items.ready = adv;

  // entry: decode the request, round the row, centre the pixel
  logic [39:0] pu_sh, pv_sh;
  logic [21:0] vr_sum, vr;
  item_t       ent;

  assign pu_sh  = 40'(items.in_u) << PIX_SHIFT;
  assign pv_sh  = 40'(items.in_v) << PIX_SHIFT;
  assign vr_sum = 22'(items.in_v) + 22'(HALF);
  assign vr     = vr_sum >> COORD_FRAC_BITS;

  always_comb begin
    ent.load      = items.mode == MODE_LOAD;
    ent.focal_bad = (focal_x == '0) || (focal_y == '0);
    ent.zbad      = 1'b0;
    ent.sat       = 1'b0;
    ent.elem      = items.table_element;
    ent.value     = items.element_value;
    if (ent.load) begin
      ent.row_bad = (32'(items.table_row) >= MAX_ROWS) ||
                    (items.table_element > 4'(ELEMS - 1));
      ent.row     = ROW_IDX_W'(items.table_row);
    end else begin
      ent.row_bad = 32'(vr) >= MAX_ROWS;
      ent.row     = ROW_IDX_W'(vr);
    end
  end

  logic                   s0_vld;
  item_t                  s0_item;
  logic signed [DU_W-1:0] s0_du_x, s0_du_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= ent;
      s0_du_x <= $signed(pu_sh - 40'(center_x));
      s0_du_y <= $signed(pv_sh - 40'(center_y));
    end
  end

  // normalise: x = du / fx, y = dv / fy in Q4.28
  logic [DU_W-1:0]               mag_x, mag_y;
  logic [1:0][NORM_N_W-1:0]      d1_num;
  logic                          d1_vld;
  logic [1:0][31:0]              d1_q;
  logic [1:0]                    d1_sat;
  logic [$bits(item_t)-1:0]      d1_side;
  item_t                         d1_item;

  assign mag_x  = s0_du_x[DU_W-1] ? DU_W'(-s0_du_x) : DU_W'(s0_du_x);
  assign mag_y  = s0_du_y[DU_W-1] ? DU_W'(-s0_du_y) : DU_W'(s0_du_y);
  assign d1_num = {{mag_y, {Q28_BITS{1'b0}}}, {mag_x, {Q28_BITS{1'b0}}}};

  lurw_div #(
    .N_W   (NORM_N_W),
    .D_W   (32),
    .SIDE_W($bits(item_t))
  ) u_div_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (s0_vld),
    .num_mag (d1_num),
    .num_neg ({s0_du_y[DU_W-1], s0_du_x[DU_W-1]}),
    .den     ({focal_y, focal_x}),
    .side_in (s0_item),
    .out_vld (d1_vld),
    .quot    (d1_q),
    .quot_sat(d1_sat),
    .side_out(d1_side)
  );

  always_comb begin
    d1_item     = item_t'(d1_side);
    d1_item.sat = d1_item.sat | d1_sat[0] | d1_sat[1];
  end

  // distortion
  logic               ds_vld;
  logic signed [31:0] ds_x2, ds_y2;
  item_t              ds_item;

  lurw_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (d1_vld),
    .x_in    ($signed(d1_q[0])),
    .y_in    ($signed(d1_q[1])),
    .item_in (d1_item),
    .k1      ($signed(radial_k1)),
    .k2      ($signed(radial_k2)),
    .p1      ($signed(tan_pair[63:32])),
    .p2      ($signed(tan_pair[31:0])),
    .out_vld (ds_vld),
    .x2      (ds_x2),
    .y2      (ds_y2),
    .item_out(ds_item)
  );

  // rolling-shutter rotation; table loads also land here
  logic               rt_vld;
  logic signed [35:0] rt_x, rt_y, rt_z;
  item_t              rt_item;

  lurw_rot #(
    .MAX_ROWS(MAX_ROWS)
  ) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (ds_vld),
    .x2      (ds_x2),
    .y2      (ds_y2),
    .item_in (ds_item),
    .out_vld (rt_vld),
    .rx      (rt_x),
    .ry      (rt_y),
    .rz      (rt_z),
    .item_out(rt_item)
  );

  // perspective divide: X / Z, Y / Z; depth of zero or below is flagged upstream
  logic [35:0]              mx, my;
  logic [1:0][PROJ_N_W-1:0] d2_num;
  logic                     d2_vld;
  logic [1:0][31:0]         d2_q;
  logic [1:0]               d2_sat;
  logic [$bits(item_t)-1:0] d2_side;
  item_t                    d2_item;

  assign mx     = rt_x[35] ? 36'(-rt_x) : 36'(rt_x);
  assign my     = rt_y[35] ? 36'(-rt_y) : 36'(rt_y);
  assign d2_num = {{my, {Q28_BITS{1'b0}}}, {mx, {Q28_BITS{1'b0}}}};

  lurw_div #(
    .N_W   (PROJ_N_W),
    .D_W   (36),
    .SIDE_W($bits(item_t))
  ) u_div_proj (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (rt_vld),
    .num_mag (d2_num),
    .num_neg ({rt_y[35], rt_x[35]}),
    .den     ({rt_z, rt_z}),
    .side_in (rt_item),
    .out_vld (d2_vld),
    .quot    (d2_q),
    .quot_sat(d2_sat),
    .side_out(d2_side)
  );

  always_comb begin
    d2_item     = item_t'(d2_side);
    d2_item.sat = d2_item.sat | d2_sat[0] | d2_sat[1];
  end

  // back to pixels and out
  lurw_proj #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_proj (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (d2_vld),
    .n_x      ($signed(d2_q[0])),
    .n_y      ($signed(d2_q[1])),
    .item_in  (d2_item),
    .focal_x  (focal_x),
    .focal_y  (focal_y),
    .center_x (center_x),
    .center_y (center_y),
    .zoom     (zoom),
    .out_ready(results.ready),
    .adv      (adv),
    .out_vld  (results.valid),
    .out_u    (results.out_u),
    .out_v    (results.out_v),
    .status   (results.status)
  );

endmodule

// ----- test/lens_undistort_rotate_warp_tb.sv -----
// Self-checking testbench for the lens undistortion and rolling-shutter rotation warp.
module lens_undistort_rotate_warp_tb;
  import lurw_pkg::*;

  localparam int  ROWS      = 4096;
  localparam int  LATENCY   = 83;
  localparam int  IDLE_MAX  = 4000;
  localparam longint Q28ONE = 64'sd268435456;
  localparam logic [23:0] SAT_OUT = 24'h7FFFFF;

  typedef struct {
    logic [23:0] out_u;
    logic [23:0] out_v;
    status_t     status;
  } warp_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lurw_in_if  req_ch ();
  lurw_out_if res_ch ();

  lens_undistort_rotate_warp DUT (
    .clk       (clk),
    .rst       (rst),
    .items     (req_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers and rotation table.
  bit [31:0] focal_x, focal_y, center_x, center_y;
  bit [23:0] zoom;
  longint    k1, k2, p1, p2;
  int        rot_table [int];
  bit        rot_written [int];
  int        loaded_rows [$];
  bit        clamp_seen;

  warp_res_t pending_warps [$];
  int  mismatches;
  int  idle_cycles;
  bit  send_idle;
  bit  recv_idle;
  int  recv_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp to the signed 32-bit range, noting any clamping.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      clamp_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clamp_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 28;
  endfunction

  // Scale a normalised Q4.28 value back to a 24-bit Q15.8 pixel coordinate.
  function automatic longint back_to_pixel(longint n, bit [31:0] f, bit [31:0] c);
    longint t;
    t = (n * longint'(f)) >>> 28;
    t = ((t * longint'(zoom)) >>> 16) + longint'(c);
    t = t >>> 8;
    if (t > 64'sd8388607) begin
      clamp_seen = 1'b1;
      t = 64'sd8388607;
    end
    if (t < -64'sd8388608) begin
      clamp_seen = 1'b1;
      t = -64'sd8388608;
    end
    return t;
  endfunction

  // Expected result of one pixel map request.
  function automatic warp_res_t warp_predict(bit [20:0] pu, bit [20:0] pv);
    warp_res_t r;
    longint vr, du, dv, x, y, xx, yy, xy, r2, r4, rad, tx, ty, x2, y2;
    longint m [9];
    longint cx, cy, cz;
    r.out_u  = SAT_OUT;
    r.out_v  = SAT_OUT;
    r.status = ST_OK;
    vr = (longint'(pv) + 128) >>> 8;
    if (vr >= ROWS) begin
      r.status = ST_ROW;
      return r;
    end
    if (focal_x == 0 || focal_y == 0) begin
      r.status = ST_BAD;
      return r;
    end
    for (int i = 0; i < 9; i++) m[i] = longint'(rot_table[int'(vr) * 9 + i]);
    clamp_seen = 1'b0;
    du  = (longint'(pu) << 8) - longint'(center_x);
    dv  = (longint'(pv) << 8) - longint'(center_y);
    x   = clamp32(du * Q28ONE / longint'(focal_x));
    y   = clamp32(dv * Q28ONE / longint'(focal_y));
    xx  = clamp32(fmul(x, x));
    yy  = clamp32(fmul(y, y));
    xy  = clamp32(fmul(x, y));
    r2  = clamp32(xx + yy);
    r4  = clamp32(fmul(r2, r2));
    rad = clamp32(Q28ONE + fmul(k1, r2) + fmul(k2, r4));
    tx  = 2 * fmul(p1, xy) + fmul(p2, clamp32(r2 + 2 * xx));
    ty  = fmul(p1, clamp32(r2 + 2 * yy)) + 2 * fmul(p2, xy);
    x2  = clamp32(fmul(x, rad) + tx);
    y2  = clamp32(fmul(y, rad) + ty);
    cx = ((m[0] * x2) >>> 30) + ((m[1] * y2) >>> 30) + ((m[2] * Q28ONE) >>> 30);
    cy = ((m[3] * x2) >>> 30) + ((m[4] * y2) >>> 30) + ((m[5] * Q28ONE) >>> 30);
    cz = ((m[6] * x2) >>> 30) + ((m[7] * y2) >>> 30) + ((m[8] * Q28ONE) >>> 30);
    if (cz <= 0) begin
      r.status = ST_BAD;
      return r;
    end
    x = clamp32(cx * Q28ONE / cz);
    y = clamp32(cy * Q28ONE / cz);
    du = back_to_pixel(x, focal_x, center_x);
    dv = back_to_pixel(y, focal_y, center_y);
    r.out_u  = du[23:0];
    r.out_v  = dv[23:0];
    r.status = clamp_seen ? ST_BAD : ST_OK;
    return r;
  endfunction

  // Apply a load to the shadow table and return its expected result.
  function automatic warp_res_t table_load(bit [11:0] row, bit [3:0] el, bit [31:0] val);
    warp_res_t r;
    bit full;
    r.out_u  = '0;
    r.out_v  = '0;
    r.status = ST_OK;
    if (el > 8) begin
      r.status = ST_ROW;
      return r;
    end
    rot_table[int'(row) * 9 + el]   = int'(val);
    rot_written[int'(row) * 9 + el] = 1'b1;
    full = 1'b1;
    for (int i = 0; i < 9; i++) if (!rot_written.exists(int'(row) * 9 + i)) full = 1'b0;
    if (full) begin
      foreach (loaded_rows[i]) if (loaded_rows[i] == int'(row)) full = 1'b0;
      if (full) loaded_rows.push_back(int'(row));
    end
    return r;
  endfunction

  // Send one request; predict its result at the edge where it is taken.
  task automatic send_request(bit mode, bit [20:0] pu, bit [20:0] pv, bit [11:0] row,
                              bit [3:0] el, bit [31:0] val);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid         = 1'b1;
    req_ch.mode          = mode;
    req_ch.in_u          = pu;
    req_ch.in_v          = pv;
    req_ch.table_row     = row;
    req_ch.table_element = el;
    req_ch.element_value = val;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    if (mode == MODE_LOAD) pending_warps.push_back(table_load(row, el, val));
    else pending_warps.push_back(warp_predict(pu, pv));
  endtask

  task automatic send_map(bit [20:0] pu, bit [20:0] pv);
    send_request(1'b1, pu, pv, $urandom, $urandom, $urandom);
  endtask

  task automatic send_load(bit [11:0] row, bit [3:0] el, bit [31:0] val);
    send_request(MODE_LOAD, $urandom, $urandom, row, el, val);
  endtask

  // Load a whole matrix: mostly a near-identity rotation, sometimes anything at all.
  task automatic load_matrix(bit [11:0] row, bit wild);
    bit [31:0] v;
    for (int e = 0; e < 9; e++) begin
      if (wild) v = $urandom;
      else if (e == 0 || e == 4 || e == 8) v = 32'h4000_0000 - $urandom_range(0, 1 << 20);
      else v = $urandom_range(0, 1 << 25) - (1 << 24);
      send_load(row, 4'(e), v);
    end
  endtask

  // Hold until every result is back, then let the pipe settle.
  task automatic drain();
    send_idle_low();
    wait (pending_warps.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic send_idle_low();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FOCAL_X:    focal_x  = val[31:0];
      REG_FOCAL_Y:    focal_y  = val[31:0];
      REG_CENTER_X:   center_x = val[31:0];
      REG_CENTER_Y:   center_y = val[31:0];
      REG_RADIAL_K1:  k1 = longint'(signed'(val[31:0]));
      REG_RADIAL_K2:  k2 = longint'(signed'(val[31:0]));
      REG_TANGENTIAL: begin
        p1 = longint'(signed'(val[63:32]));
        p2 = longint'(signed'(val[31:0]));
      end
      REG_ZOOM:       zoom = val[23:0];
      default: ;
    endcase
  endtask

  task automatic write_all(bit [31:0] fx, bit [31:0] fy, bit [31:0] cx, bit [31:0] cy,
                           bit [31:0] rk1, bit [31:0] rk2, bit [63:0] tp, bit [23:0] zm);
    drain();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIAL_K1, rk1);
    write_reg(REG_RADIAL_K2, rk2);
    write_reg(REG_TANGENTIAL, tp);
    write_reg(REG_ZOOM, zm);
  endtask

  // A realistic camera: focal near 800 px, centre near 960x540, mild distortion.
  task automatic write_typical();
    write_all((32'd700 + $urandom_range(0, 200)) << 16, (32'd700 + $urandom_range(0, 200)) << 16,
              32'd960 << 16, 32'd540 << 16,
              $urandom_range(0, 1 << 27) - (1 << 26), $urandom_range(0, 1 << 25) - (1 << 24),
              {32'($urandom_range(0, 1 << 21) - (1 << 20)),
               32'($urandom_range(0, 1 << 21) - (1 << 20))},
              24'h010000 + $urandom_range(0, 1 << 14) - (1 << 13));
  endtask

  // Pick a map coordinate: mostly on a loaded row, sometimes past the table.
  task automatic random_map();
    int row, pv;
    if (loaded_rows.size() != 0 && $urandom_range(0, 15) != 0) begin
      row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
      pv  = row * 256 + int'($urandom_range(0, 255)) - 128;
      if (pv < 0) pv = 0;
      if ($urandom_range(0, 1)) send_map($urandom_range(0, 2047 << 8), 21'(pv));
      else send_map($urandom, 21'(pv));
    end else begin
      send_map($urandom, $urandom_range(21'd1048448, 21'h1FFFFF));
    end
  endtask

  task automatic random_traffic(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          load_matrix($urandom, $urandom_range(0, 4) == 0);
          sent += 9;
        end
        2: begin
          // Bad element index: ignored by the table.
          send_load($urandom, $urandom_range(9, 15), $urandom);
          sent++;
        end
        3: begin
          // Rewrite one element of an already complete row.
          if (loaded_rows.size() != 0)
            send_load(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)],
                      $urandom_range(0, 8), $urandom);
          else send_load($urandom, $urandom_range(9, 15), $urandom);
          sent++;
        end
        default: begin
          random_map();
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_directed();
    load_matrix(12'd0, 1'b0);
    // Row 4095 holds the extreme element values.
    for (int e = 0; e < 9; e++)
      send_load(12'd4095, 4'(e), (e % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
    send_load(12'd7, 4'd9, 32'h1234_5678);
    send_load(12'd7, 4'd15, 32'hFFFF_FFFF);
    send_map(21'd0, 21'd0);
    send_map(21'h1FFFFF, 21'd127);
    send_map(21'd1000, 21'd4095 * 256 + 127);
    send_map(21'd1000, 21'd1048448);
    send_map(21'h1FFFFF, 21'h1FFFFF);
  endtask

  task automatic test_typical_camera();
    write_typical();
    random_traffic(450);
  endtask

  task automatic test_register_extremes();
    write_all(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    random_traffic(150);
    write_all(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0,
              32'h7FFF_FFFF, 32'h8000_0000, 64'h7FFF_FFFF_8000_0000, 24'd1);
    random_traffic(100);
  endtask

  task automatic test_zero_focal();
    write_all(32'd0, 32'd800 << 16, 32'd960 << 16, 32'd540 << 16, 32'd0, 32'd0, 64'd0, 24'd0);
    random_traffic(60);
    write_all(32'd800 << 16, 32'd0, 32'd960 << 16, 32'd540 << 16, 32'd0, 32'd0, 64'd0,
              24'h010000);
    random_traffic(60);
  endtask

  task automatic test_random_registers();
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              {$urandom, $urandom}, $urandom);
    random_traffic(250);
  endtask

  task automatic test_full_rate();
    write_typical();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_traffic(500);
  endtask

  // Receiver back-pressure: random stall bursts.
  initial begin
    res_ch.ready = 1'b1;
    recv_hold = 0;
    forever begin
      @(negedge clk);
      if (!recv_idle) begin
        res_ch.ready = 1'b1;
      end else if (recv_hold > 0) begin
        recv_hold--;
        res_ch.ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_hold = $urandom_range(0, 4);
        res_ch.ready = 1'b0;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Compare each taken result against the oldest expectation; watch for a hang.
  always @(posedge clk) begin
    warp_res_t want;
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        if (pending_warps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result u=%h v=%h status=%0d",
                                         res_ch.out_u, res_ch.out_v, res_ch.status);
        end else begin
          want = pending_warps.pop_front();
          if (res_ch.out_u !== want.out_u || res_ch.out_v !== want.out_v ||
              res_ch.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected u=%h v=%h status=%0d, got u=%h v=%h status=%0d",
                       want.out_u, want.out_v, want.status,
                       res_ch.out_u, res_ch.out_v, res_ch.status);
          end
        end
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("lens_undistort_rotate_warp_tb failed");
        $finish;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = 1'b0;
    req_ch.in_u = '0;
    req_ch.in_v = '0;
    req_ch.table_row = '0;
    req_ch.table_element = '0;
    req_ch.element_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    mismatches = 0;
    idle_cycles = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    focal_x = FOCAL_RESET;
    focal_y = FOCAL_RESET;
    center_x = 0;
    center_y = 0;
    zoom = ZOOM_RESET;
    k1 = 0;
    k2 = 0;
    p1 = 0;
    p2 = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_typical_camera();
    test_register_extremes();
    test_zero_focal();
    test_random_registers();
    test_full_rate();
    drain();

    if (mismatches == 0 && pending_warps.size() == 0)
      $display("lens_undistort_rotate_warp_tb passed");
    else
      $display("lens_undistort_rotate_warp_tb failed");
    $finish;
  end

endmodule

// ----- lens_undistort_rotate_warp.f -----
hdl/lurw_pkg.sv
hdl/lurw_if.sv
hdl/lurw_div.sv
hdl/lurw_dist.sv
hdl/lurw_rot.sv
hdl/lurw_proj.sv
hdl/lens_undistort_rotate_warp.sv
test/lens_undistort_rotate_warp_tb.sv
